>>> rtl/tils_pkg.sv
// ----------------------------------------------------------------------------
// Thumb idle loop scanner package
// Shared widths, verdict codes, beat structure and opcode decode constants.
// ----------------------------------------------------------------------------
package tils_pkg;

    localparam int MAX_STEPS    = 64;
    localparam int STEP_W       = $clog2(MAX_STEPS + 1);
    localparam int ADDR_W       = 32;
    localparam int OP_W         = 16;
    localparam int STEPS_USED_W = 7;

    typedef enum logic [1:0] {
        VERDICT_CONT   = 2'd0,
        VERDICT_REJECT = 2'd1,
        VERDICT_IDLE   = 2'd2,
        VERDICT_NONE   = 2'd3
    } verdict_t;

    typedef struct packed {
        logic              start_req;
        logic [ADDR_W-1:0] head_pc;
        logic [OP_W-1:0]   opcode;
    } scan_item_t;

    // Opcode classes, compared against the top five, four or three opcode bits or under a mask.
    localparam logic [4:0]  OPC5_B_UNCOND  = 5'h1C;
    localparam logic [4:0]  OPC5_BL_MIN    = 5'h1E;
    localparam logic [4:0]  OPC5_LDR_PC    = 5'h09;
    localparam logic [3:0]  OPC4_B_COND    = 4'hD;
    localparam logic [3:0]  OPC4_LS_WORD   = 4'h6;
    localparam logic [3:0]  OPC4_LS_REG    = 4'h5;
    localparam logic [3:0]  OPC4_MISC      = 4'hB;
    localparam logic [2:0]  OPC3_ALU_MAX   = 3'd1;
    localparam logic [15:0] BX_MASK        = 16'hFF80;
    localparam logic [15:0] BX_PATTERN     = 16'h4700;
    localparam logic [15:0] MISC_MASK      = 16'h0700;
    localparam logic [15:0] MISC_PATTERN   = 16'h0100;

    // Memory regions by the top address byte.
    localparam logic [7:0]  RGN_EWRAM      = 8'h02;
    localparam logic [7:0]  RGN_IWRAM      = 8'h03;
    localparam logic [7:0]  RGN_IO         = 8'h04;
    localparam logic [7:0]  RGN_VRAM       = 8'h06;
    localparam logic [7:0]  RGN_ROM_LO     = 8'h08;
    localparam logic [7:0]  RGN_ROM_HI     = 8'h0D;

    localparam logic [ADDR_W-1:0] IO_OK_0  = 32'h0400_0004;
    localparam logic [ADDR_W-1:0] IO_OK_1  = 32'h0400_0006;
    localparam logic [ADDR_W-1:0] IO_OK_2  = 32'h0400_0130;
    localparam logic [ADDR_W-1:0] IO_OK_3  = 32'h0400_0132;
    localparam logic [ADDR_W-1:0] IO_OK_4  = 32'h0400_0200;
    localparam logic [ADDR_W-1:0] IO_OK_5  = 32'h0400_0202;

endpackage

>>> rtl/tils_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted input beat until the scan stage takes it.
// ----------------------------------------------------------------------------
module tils_in_reg import tils_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  scan_item_t s_item,
    output logic       q_valid,
    output scan_item_t q_item,
    input  logic       q_take
);

    logic       valid_reg, valid_next;
    scan_item_t item_reg, item_next;
    logic       load;

    // The register frees up in the same cycle that its beat moves on.
    assign s_ready = !valid_reg || q_take;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (load) begin
            valid_next = 1'b1;
            item_next  = s_item;
        end else if (q_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

>>> rtl/tils_decode.sv
// ----------------------------------------------------------------------------
// Opcode classifier
// Gives the verdict for one Thumb opcode at a given address and loop head.
// ----------------------------------------------------------------------------
module tils_decode import tils_pkg::*; (
    input  logic [ADDR_W-1:0] addr,
    input  logic [ADDR_W-1:0] head,
    input  logic [OP_W-1:0]   opcode,
    output verdict_t          verdict
);

    logic [ADDR_W-1:0] pc4;
    logic [ADDR_W-1:0] b_target;
    logic [ADDR_W-1:0] bcc_target;
    logic [ADDR_W-1:0] lit_addr;
    logic [ADDR_W-1:0] lit_even;
    logic [7:0]        rgn;
    logic              io_ok;
    verdict_t          lit_verdict;

    assign pc4        = addr + 32'd4;
    assign b_target   = pc4 + {{20{opcode[10]}}, opcode[10:0], 1'b0};
    assign bcc_target = pc4 + {{23{opcode[7]}}, opcode[7:0], 1'b0};

    // The literal base is the PC plus four with bit 1 cleared.
    assign lit_addr   = {pc4[31:2], 1'b0, pc4[0]} + {22'd0, opcode[7:0], 2'b00};
    assign lit_even   = {lit_addr[31:1], 1'b0};
    assign rgn        = lit_addr[31:24];

    assign io_ok = (lit_even == IO_OK_0) || (lit_even == IO_OK_1) ||
                   (lit_even == IO_OK_2) || (lit_even == IO_OK_3) ||
                   (lit_even == IO_OK_4) || (lit_even == IO_OK_5);

    always_comb begin
        if (rgn == RGN_EWRAM || rgn == RGN_IWRAM || rgn == RGN_VRAM) begin
            lit_verdict = VERDICT_CONT;
        end else if (rgn >= RGN_ROM_LO && rgn <= RGN_ROM_HI) begin
            lit_verdict = VERDICT_CONT;
        end else if (rgn == RGN_IO && io_ok) begin
            lit_verdict = VERDICT_CONT;
        end else begin
            lit_verdict = VERDICT_REJECT;
        end
    end

    always_comb begin
        if (opcode[15:11] == OPC5_B_UNCOND) begin
            verdict = (b_target == head) ? VERDICT_IDLE : VERDICT_REJECT;
        end else if (opcode[15:12] == OPC4_B_COND) begin
            verdict = (bcc_target == head) ? VERDICT_IDLE : VERDICT_REJECT;
        end else if (opcode[15:11] >= OPC5_BL_MIN) begin
            verdict = VERDICT_REJECT;
        end else if ((opcode & BX_MASK) == BX_PATTERN) begin
            verdict = VERDICT_REJECT;
        end else if (opcode[15:11] == OPC5_LDR_PC) begin
            verdict = lit_verdict;
        end else if (opcode[15:12] == OPC4_LS_WORD) begin
            // Loads are harmless here; stores are not.
            verdict = opcode[11] ? VERDICT_CONT : VERDICT_REJECT;
        end else if (opcode[15:12] == OPC4_LS_REG) begin
            verdict = VERDICT_REJECT;
        end else if (opcode[15:13] <= OPC3_ALU_MAX) begin
            verdict = VERDICT_CONT;
        end else if (opcode[15:12] == OPC4_MISC && (opcode & MISC_MASK) == MISC_PATTERN) begin
            verdict = VERDICT_REJECT;
        end else begin
            verdict = VERDICT_CONT;
        end
    end

endmodule

>>> rtl/thumb_idle_loop_scanner.sv
// ----------------------------------------------------------------------------
// Thumb idle loop scanner
// Classifies a run of Thumb opcodes from a loop head as an idle loop or not.
// ----------------------------------------------------------------------------
// Each accepted input beat passes through the input register and then the
// result register, one beat per cycle while m_ready does not stall the output;
// the scan state is read and updated by a single decode pass between them.
// Reset (aresetn low, synchronous) empties both registers and ends any scan.
// ----------------------------------------------------------------------------
module thumb_idle_loop_scanner import tils_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_start_req,
    input  logic [ADDR_W-1:0]       s_head_pc,
    input  logic [OP_W-1:0]         s_opcode,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_verdict,
    output logic [STEPS_USED_W-1:0] m_steps_used
);

    scan_item_t s_item;
    scan_item_t q_item;
    logic       q_valid;
    logic       q_take;
    logic       out_free;

    logic [ADDR_W-1:0]       scan_addr_reg, scan_addr_next;
    logic [ADDR_W-1:0]       loop_head_reg, loop_head_next;
    logic [STEP_W-1:0]       step_cnt_reg, step_cnt_next;
    logic                    active_reg, active_next;
    logic                    m_valid_reg, m_valid_next;
    verdict_t                m_verdict_reg, m_verdict_next;
    logic [STEPS_USED_W-1:0] m_steps_reg, m_steps_next;

    // Scan state as seen by the current beat, after a possible restart.
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] cur_head;
    logic [STEP_W-1:0] cur_cnt;
    logic              cur_active;
    logic [STEP_W-1:0] cnt_inc;
    logic [ADDR_W-1:0] addr_inc;
    verdict_t          dec_verdict;

    assign s_item = '{start_req: s_start_req, head_pc: s_head_pc, opcode: s_opcode};

    tils_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_take  (q_take)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign q_take   = q_valid && out_free;

    assign cur_addr   = q_item.start_req ? q_item.head_pc : scan_addr_reg;
    assign cur_head   = q_item.start_req ? q_item.head_pc : loop_head_reg;
    assign cur_cnt    = q_item.start_req ? '0 : step_cnt_reg;
    assign cur_active = q_item.start_req || active_reg;
    assign cnt_inc    = cur_cnt + STEP_W'(1);
    assign addr_inc   = cur_addr + 32'd2;

    tils_decode u_decode (
        .addr    (cur_addr),
        .head    (cur_head),
        .opcode  (q_item.opcode),
        .verdict (dec_verdict)
    );

    always_comb begin
        scan_addr_next = scan_addr_reg;
        loop_head_next = loop_head_reg;
        step_cnt_next  = step_cnt_reg;
        active_next    = active_reg;
        m_verdict_next = m_verdict_reg;
        m_steps_next   = m_steps_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        if (q_take) begin
            m_valid_next   = 1'b1;
            scan_addr_next = cur_addr;
            loop_head_next = cur_head;
            step_cnt_next  = cur_cnt;
            active_next    = cur_active;
            if (!cur_active) begin
                m_verdict_next = VERDICT_NONE;
                m_steps_next   = '0;
            end else begin
                step_cnt_next = cnt_inc;
                m_steps_next  = STEPS_USED_W'(cnt_inc);
                m_verdict_next = dec_verdict;
                if (dec_verdict == VERDICT_CONT) begin
                    // Wrapping onto the head or running out of steps ends the scan.
                    if (addr_inc == cur_head || cnt_inc >= STEP_W'(MAX_STEPS)) begin
                        m_verdict_next = VERDICT_REJECT;
                        active_next    = 1'b0;
                    end else begin
                        scan_addr_next = addr_inc;
                    end
                end else begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_addr_reg <= '0;
            loop_head_reg <= '0;
            step_cnt_reg  <= '0;
            active_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            scan_addr_reg <= scan_addr_next;
            loop_head_reg <= loop_head_next;
            step_cnt_reg  <= step_cnt_next;
            active_reg    <= active_next;
            m_valid_reg   <= m_valid_next;
        end
        m_verdict_reg <= m_verdict_next;
        m_steps_reg   <= m_steps_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_verdict    = m_verdict_reg;
    assign m_steps_used = m_steps_reg;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thumb idle loop scanner testbench
// Drives opcode runs from random loop heads through the input channel. It
// tracks the scan in a local model and checks each verdict and step count in
// order. Traffic runs under several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import tils_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        verdict_t                verdict;
        logic [STEPS_USED_W-1:0] steps;
    } verdict_beat_t;

    // Scan model plus the verdicts still owed by the block, oldest first.
    class verdict_scoreboard;
        logic [ADDR_W-1:0]       scan_addr;
        logic [ADDR_W-1:0]       head;
        logic [STEP_W-1:0]       steps;
        bit                      active;
        verdict_beat_t           owed[$];
        int                      err_count;

        function new();
            scan_addr = '0;
            head      = '0;
            steps     = '0;
            active    = 1'b0;
            err_count = 0;
        endfunction

        function verdict_t literal_class(logic [ADDR_W-1:0] lit);
            logic [7:0]        rgn;
            logic [ADDR_W-1:0] io;
            rgn = lit[31:24];
            io  = {lit[31:1], 1'b0};
            if (rgn == RGN_EWRAM || rgn == RGN_IWRAM || rgn == RGN_VRAM)
                return VERDICT_CONT;
            if (rgn >= RGN_ROM_LO && rgn <= RGN_ROM_HI)
                return VERDICT_CONT;
            if (rgn == RGN_IO && (io == IO_OK_0 || io == IO_OK_1 || io == IO_OK_2 ||
                                  io == IO_OK_3 || io == IO_OK_4 || io == IO_OK_5))
                return VERDICT_CONT;
            return VERDICT_REJECT;
        endfunction

        function verdict_t classify(logic [ADDR_W-1:0] a, logic [OP_W-1:0] op);
            logic [ADDR_W-1:0] tgt;
            logic [ADDR_W-1:0] lit;
            if (op[15:11] == OPC5_B_UNCOND) begin
                tgt = a + 32'd4 + {{20{op[10]}}, op[10:0], 1'b0};
                return (tgt == head) ? VERDICT_IDLE : VERDICT_REJECT;
            end
            if (op[15:12] == OPC4_B_COND) begin
                tgt = a + 32'd4 + {{23{op[7]}}, op[7:0], 1'b0};
                return (tgt == head) ? VERDICT_IDLE : VERDICT_REJECT;
            end
            if (op[15:11] >= OPC5_BL_MIN)
                return VERDICT_REJECT;
            if ((op & BX_MASK) == BX_PATTERN)
                return VERDICT_REJECT;
            if (op[15:11] == OPC5_LDR_PC) begin
                lit = ((a + 32'd4) & ~32'h2) + {22'd0, op[7:0], 2'b00};
                return literal_class(lit);
            end
            if (op[15:12] == OPC4_LS_WORD)
                return op[11] ? VERDICT_CONT : VERDICT_REJECT;
            if (op[15:12] == OPC4_LS_REG)
                return VERDICT_REJECT;
            if (op[15:13] <= OPC3_ALU_MAX)
                return VERDICT_CONT;
            if (op[15:12] == OPC4_MISC && (op & MISC_MASK) == MISC_PATTERN)
                return VERDICT_REJECT;
            return VERDICT_CONT;
        endfunction

        // Advances the model by one accepted input beat and queues its verdict.
        function verdict_t predict_verdict(logic st, logic [ADDR_W-1:0] hp,
                                           logic [OP_W-1:0] op);
            verdict_t          v;
            logic [ADDR_W-1:0] nxt;
            if (st) begin
                head      = hp;
                scan_addr = hp;
                steps     = '0;
                active    = 1'b1;
            end
            if (!active) begin
                owed.push_back('{VERDICT_NONE, '0});
                return VERDICT_NONE;
            end
            steps = steps + STEP_W'(1);
            v = classify(scan_addr, op);
            if (v == VERDICT_CONT) begin
                nxt = scan_addr + 32'd2;
                if (nxt == head || steps >= STEP_W'(MAX_STEPS))
                    v = VERDICT_REJECT;
                else
                    scan_addr = nxt;
            end
            if (v != VERDICT_CONT)
                active = 1'b0;
            owed.push_back('{v, STEPS_USED_W'(steps)});
            return v;
        endfunction

        function void check_verdict(logic [1:0] v, logic [STEPS_USED_W-1:0] st);
            verdict_beat_t e;
            if (owed.size() == 0) begin
                $error("result beat with no verdict pending: verdict %0d steps_used %0d",
                       v, st);
                err_count++;
                return;
            end
            e = owed.pop_front();
            if (v !== e.verdict) begin
                $error("verdict: expected %0d, got %0d", e.verdict, v);
                err_count++;
            end
            if (st !== e.steps) begin
                $error("steps_used: expected %0d, got %0d", e.steps, st);
                err_count++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_start_req = 1'b0;
    logic [ADDR_W-1:0]       s_head_pc = '0;
    logic [OP_W-1:0]         s_opcode = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [1:0]              m_verdict;
    logic [STEPS_USED_W-1:0] m_steps_used;

    verdict_scoreboard sb = new();
    int                s_idle_pct = 0;
    int                m_stall_pct = 0;
    int                scored_beats = 0;
    int                cycles = 0;

    thumb_idle_loop_scanner dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_req  (s_start_req),
        .s_head_pc    (s_head_pc),
        .s_opcode     (s_opcode),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_verdict    (m_verdict),
        .m_steps_used (m_steps_used)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= m_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_verdict(m_verdict, m_steps_used);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("thumb_idle_loop_scanner regression: fail");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task send_beat(input logic st, input logic [ADDR_W-1:0] hp, input logic [OP_W-1:0] op);
        verdict_t v;
        if ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(0, 99) < s_idle_pct)
                @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_start_req <= st;
        s_head_pc   <= hp;
        s_opcode    <= op;
        do @(posedge aclk); while (!s_ready);
        v = sb.predict_verdict(st, hp, op);
        if (v != VERDICT_NONE)
            scored_beats++;
        @(negedge aclk);
    endtask

    task drain_verdicts();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
    endtask

    function logic [ADDR_W-1:0] pick_head();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return {8'h08 + 8'($urandom_range(0, 5)), 24'($urandom)};
            2: return 32'hFFFF_FF00 | $urandom_range(0, 255);
            3: return 32'h0400_0000 | $urandom_range(0, 12'h1FF);
            default: return {8'h02 + 8'($urandom_range(0, 1)), 24'($urandom)};
        endcase
    endfunction

    // An opcode that keeps the scan going; a PC-relative load may still reject.
    function logic [OP_W-1:0] pass_opcode(bit allow_literal);
        logic [11:0] low;
        case ($urandom_range(0, allow_literal ? 7 : 6))
            0: return 16'($urandom_range(0, 16'h3FFF));
            1: return 16'h6800 | 16'($urandom_range(0, 16'h07FF));
            2: return 16'($urandom_range(16'h4000, 16'h46FF));
            3: return 16'($urandom_range(16'h7000, 16'hAFFF));
            4: begin
                low = 12'($urandom);
                if (low[10:8] == 3'b001)
                    low[9] = 1'b1;
                return {4'hB, low};
            end
            5: return 16'($urandom_range(16'hC000, 16'hCFFF));
            6: return 16'($urandom_range(16'hE800, 16'hEFFF));
            default: return 16'h4800 | 16'($urandom_range(0, 255));
        endcase
    endfunction

    // A start beat, a body of passing opcodes, then a closing opcode that is
    // usually a branch back to the head.
    task scan_sequence(input int body_len, input bit long_run);
        logic [ADDR_W-1:0] hd;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] back;
        logic [OP_W-1:0]   tail;
        int                i;
        int                pick;
        hd = pick_head();
        a  = hd;
        for (i = 0; i < body_len; i++) begin
            send_beat(i == 0, (i == 0) ? hd : $urandom, pass_opcode(!long_run));
            a = a + 32'd2;
        end
        back = hd - a - 32'd4;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            tail = {5'h1C, back[11:1]};
        else if (pick < 80)
            tail = {4'hD, 4'($urandom), back[8:1]};
        else if (pick < 90)
            tail = {5'h1C, 11'($urandom)};
        else
            tail = 16'($urandom);
        send_beat(body_len == 0, (body_len == 0) ? hd : $urandom, tail);
    endtask

    task noise_burst(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_beat($urandom_range(0, 7) == 0, $urandom, 16'($urandom));
    endtask

    task random_phase(input int s_pct, input int m_pct, input int beats);
        int goal;
        int kind;
        s_idle_pct  = s_pct;
        m_stall_pct = m_pct;
        goal = scored_beats + beats;
        while (scored_beats < goal) begin
            kind = $urandom_range(0, 99);
            if (kind < 6)
                scan_sequence($urandom_range(60, 66), 1'b1);
            else if (kind < 72)
                scan_sequence($urandom_range(0, 12), 1'b0);
            else if (kind < 86)
                noise_burst($urandom_range(1, 8));
            else
                noise_burst($urandom_range(1, 4));
        end
        drain_verdicts();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed beats: no scan, self branches, literal regions, IO whitelist,
        // every rejecting class, address wrap through zero, restart mid-scan.
        send_beat(1'b0, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(1'b1, 32'h0800_0000, 16'hE7FE);
        send_beat(1'b0, 32'h0000_0000, 16'h0000);
        send_beat(1'b1, 32'h0800_0100, 16'hD0FE);
        send_beat(1'b1, 32'h0300_0000, 16'h4800);
        send_beat(1'b0, 32'h0000_0000, 16'h6FFF);
        send_beat(1'b0, 32'h0000_0000, 16'h3FFF);
        send_beat(1'b0, 32'h0000_0000, 16'h6000);
        send_beat(1'b1, 32'h0400_0000, 16'h4800);
        send_beat(1'b0, 32'h0000_0000, 16'h484B);
        send_beat(1'b0, 32'h0000_0000, 16'h487E);
        send_beat(1'b0, 32'h0000_0000, 16'h4700);
        send_beat(1'b1, 32'h0400_0000, 16'h4801);
        send_beat(1'b1, 32'h0000_1000, 16'h48FF);
        send_beat(1'b1, 32'h0D00_0000, 16'h5000);
        send_beat(1'b1, 32'h06FF_FF00, 16'h48FF);
        send_beat(1'b1, 32'h0200_0000, 16'h4800);
        send_beat(1'b0, 32'h0000_0000, 16'hF800);
        send_beat(1'b1, 32'h0800_0000, 16'hB100);
        send_beat(1'b1, 32'h0800_0000, 16'hB000);
        send_beat(1'b0, 32'h0000_0000, 16'hE800);
        send_beat(1'b0, 32'h0000_0000, 16'hE000);
        send_beat(1'b1, 32'hFFFF_FFFE, 16'h0000);
        send_beat(1'b0, 32'h0000_0000, 16'hE7FD);
        send_beat(1'b1, 32'h0800_0000, 16'h1C00);
        send_beat(1'b1, 32'h0800_0002, 16'hDFFE);
        drain_verdicts();

        random_phase(0, 0, 270);
        random_phase(65, 0, 270);
        random_phase(0, 65, 270);
        random_phase(32, 32, 270);
        random_phase(0, 0, 270);

        repeat (10) @(posedge aclk);
        if (sb.err_count == 0 && sb.pending() == 0)
            $display("thumb_idle_loop_scanner regression: pass");
        else
            $display("thumb_idle_loop_scanner regression: fail");
        $finish;
    end
endmodule

>>> sim.f
rtl/tils_pkg.sv
rtl/tils_in_reg.sv
rtl/tils_decode.sv
rtl/thumb_idle_loop_scanner.sv
test/tb_top.sv
